@@ rtl/core/psc_pkg.sv @@
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants of the pair sum counter.
// ----------------------------------------------------------------------------
package psc_pkg;

   localparam int MODE_W  = 2;
   localparam int VALUE_W = 10;
   localparam int SUM_W   = 11;
   localparam int PAIR_W  = 33;

   // request opcodes; code 3 is unused and ignored
   localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // per-pair control that travels alongside the bin reads
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

endpackage

@@ rtl/core/psc_ram.sv @@
// ----------------------------------------------------------------------------
// psc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module psc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/core/psc_mac.sv @@
// ----------------------------------------------------------------------------
// psc_mac
// Multiply-accumulate for bin pairs: product register, then 33-bit sum.
// ----------------------------------------------------------------------------
module psc_mac #(
   parameter int COUNT_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  psc_pkg::mac_ctl_type        ctl,
   input  logic [COUNT_BITS-1:0]       op_a,
   input  logic [COUNT_BITS-1:0]       op_b,
   output logic                        done,
   output logic [psc_pkg::PAIR_W-1:0]  total
);

   import psc_pkg::*;

   localparam int PROD_W = 2 * COUNT_BITS;

   mac_ctl_type              ctl_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [PAIR_W+PROD_W-1:0] prod_pad;
   logic [PAIR_W-1:0]        acc_ff;
   logic [PAIR_W-1:0]        acc_in;
   logic                     done_ff;

   // result is kept modulo 2^PAIR_W
   assign prod_pad = {{PAIR_W{1'b0}}, prod_ff};
   assign acc_in   = (ctl_ff.first ? '0 : acc_ff) + prod_pad[PAIR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         ctl_ff  <= ctl;
         done_ff <= ctl_ff.valid & ctl_ff.last;
      end
      prod_ff <= op_a * op_b;
      if (ctl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign done  = done_ff;
   assign total = acc_ff;

endmodule

@@ rtl/core/pair_sum_counter_core.sv @@
// ----------------------------------------------------------------------------
// pair_sum_counter_core
// Histogram of loaded values with exact pair-sum (self-convolution) queries.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Add requests bump
// the bin of req_value with busy high in ST_ADD_WR (read, then write back the
// incremented count), or at the count limit only set the overflow flag. Clear
// requests zero every bin with a sweep of the bin memory, one bin per cycle,
// busy staying high until the last bin is written. The same sweep runs after
// reset; no request is taken until it is done. A query for sum s walks the
// n = hi - lo + 1 bin pairs (k, s-k) that fit in the histogram, reading both
// bins of one pair per cycle from the two read ports of the bin memory and
// feeding a registered multiplier and accumulator (n is BIN_COUNT at most).
// The single response pulses rsp_strobe for one cycle, as busy drops, once
// the last pair has passed the read, product and accumulator registers; a
// query with no fitting pair answers zero on the cycle after acceptance.
// There is no back-pressure on the response side: the response must be
// captured in the cycle it is strobed.
// Add and clear requests give no response; mode 3 is ignored.
// ----------------------------------------------------------------------------
module pair_sum_counter_core #(
   parameter int BIN_COUNT  = 1024,
   parameter int COUNT_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [psc_pkg::MODE_W-1:0]   req_mode,
   input  logic [psc_pkg::VALUE_W-1:0]  req_value,
   input  logic [psc_pkg::SUM_W-1:0]    req_sum_index,
   output logic                         rsp_strobe,
   output logic [psc_pkg::SUM_W-1:0]    rsp_sum_echo,
   output logic [psc_pkg::PAIR_W-1:0]   rsp_pair_count,
   output logic                         rsp_overflowed
);

   import psc_pkg::*;

   localparam int BIN_BITS = $clog2(BIN_COUNT);
   // walk index must hold both the sum and the top bin
   localparam int WK_W     = (BIN_BITS > SUM_W) ? BIN_BITS : SUM_W;
   // range check width for the incoming value
   localparam int RW       = ((BIN_BITS > VALUE_W) ? BIN_BITS : VALUE_W) + 1;

   localparam logic [WK_W-1:0]       TOP_BIN     = WK_W'(BIN_COUNT - 1);
   localparam logic [BIN_BITS-1:0]   LAST_ADDR   = BIN_BITS'(BIN_COUNT - 1);
   localparam logic [RW-1:0]         BIN_LIMIT   = RW'(BIN_COUNT);
   localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_WR,
      ST_CLEAR,
      ST_QUERY,
      ST_DRAIN
   } state_type;

   state_type               state_ff;
   logic [BIN_BITS-1:0]     clr_ff;
   logic [BIN_BITS-1:0]     add_addr_ff;
   logic [COUNT_BITS-1:0]   item_total_ff;
   logic                    overflow_ff;
   logic [SUM_W-1:0]        s_ff;
   logic [WK_W-1:0]         k_ff;
   logic [WK_W-1:0]         hi_ff;
   logic                    first_ff;
   mac_ctl_type             rd_ctl_ff;
   logic                    rsp_strobe_ff;
   logic [SUM_W-1:0]        rsp_sum_echo_ff;
   logic [PAIR_W-1:0]       rsp_pair_count_ff;
   logic                    rsp_overflowed_ff;

   logic                    accept;
   logic [RW-1:0]           value_ext;
   logic                    value_ok;
   logic [BIN_BITS+VALUE_W-1:0] value_pad;
   logic [BIN_BITS-1:0]     value_addr;
   logic [WK_W-1:0]         s_ext;
   logic [WK_W-1:0]         lo_calc;
   logic [WK_W-1:0]         hi_calc;
   logic [WK_W-1:0]         pair_idx;
   mac_ctl_type             issue_ctl;

   logic                    wr_en;
   logic [BIN_BITS-1:0]     wr_addr;
   logic [COUNT_BITS-1:0]   wr_data;
   logic [BIN_BITS-1:0]     rd_addr_a;
   logic [BIN_BITS-1:0]     rd_addr_b;
   logic [COUNT_BITS-1:0]   rd_data_a;
   logic [COUNT_BITS-1:0]   rd_data_b;
   logic                    mac_done;
   logic [PAIR_W-1:0]       mac_total;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   // add path: range check and bin address
   assign value_ext  = RW'(req_value);
   assign value_ok   = (value_ext < BIN_LIMIT);
   assign value_pad  = {{BIN_BITS{1'b0}}, req_value};
   assign value_addr = value_pad[BIN_BITS-1:0];

   // query bounds: k runs lo..hi so that both k and s-k are valid bins
   assign s_ext   = WK_W'(req_sum_index);
   assign lo_calc = (s_ext > TOP_BIN) ? (s_ext - TOP_BIN) : '0;
   assign hi_calc = (s_ext < TOP_BIN) ? s_ext : TOP_BIN;

   // partner bin of the current walk index
   assign pair_idx = WK_W'(s_ff) - k_ff;

   assign issue_ctl.valid = (state_ff == ST_QUERY);
   assign issue_ctl.first = first_ff;
   assign issue_ctl.last  = (k_ff == hi_ff);

   // memory port steering; read of an add address happens in the accept cycle
   assign rd_addr_a = (state_ff == ST_QUERY) ? k_ff[BIN_BITS-1:0] : value_addr;
   assign rd_addr_b = pair_idx[BIN_BITS-1:0];
   assign wr_en     = (state_ff == ST_ADD_WR) || (state_ff == ST_CLEAR);
   assign wr_addr   = (state_ff == ST_CLEAR) ? clr_ff : add_addr_ff;
   assign wr_data   = (state_ff == ST_CLEAR) ? '0 : (rd_data_a + COUNT_BITS'(1));

   psc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (BIN_COUNT)
   ) u_bins (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   psc_mac #(
      .COUNT_BITS (COUNT_BITS)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (rd_ctl_ff),
      .op_a  (rd_data_a),
      .op_b  (rd_data_b),
      .done  (mac_done),
      .total (mac_total)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;   // sweep the bins after reset
         clr_ff        <= '0;
         item_total_ff <= '0;
         overflow_ff   <= 1'b0;
         first_ff      <= 1'b0;
         rd_ctl_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         rd_ctl_ff     <= issue_ctl;   // aligned with the memory read latency
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_mode)
                     MODE_ADD: begin
                        if (value_ok) begin
                           if (item_total_ff == COUNT_LIMIT) begin
                              overflow_ff <= 1'b1;
                           end else begin
                              item_total_ff <= item_total_ff + COUNT_BITS'(1);
                              add_addr_ff   <= value_addr;
                              state_ff      <= ST_ADD_WR;
                           end
                        end
                     end
                     MODE_QUERY: begin
                        rsp_sum_echo_ff   <= req_sum_index;
                        rsp_overflowed_ff <= overflow_ff;
                        s_ff              <= req_sum_index;
                        k_ff              <= lo_calc;
                        hi_ff             <= hi_calc;
                        first_ff          <= 1'b1;
                        if (lo_calc > hi_calc) begin
                           // no bin pair fits this sum
                           rsp_pair_count_ff <= '0;
                           rsp_strobe_ff     <= 1'b1;
                        end else begin
                           state_ff <= ST_QUERY;
                        end
                     end
                     MODE_CLEAR: begin
                        item_total_ff <= '0;
                        overflow_ff   <= 1'b0;
                        clr_ff        <= '0;
                        state_ff      <= ST_CLEAR;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_ADD_WR: begin
               state_ff <= ST_IDLE;
            end
            ST_CLEAR: begin
               if (clr_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end else begin
                  clr_ff <= clr_ff + BIN_BITS'(1);
               end
            end
            ST_QUERY: begin
               first_ff <= 1'b0;
               k_ff     <= k_ff + WK_W'(1);
               if (issue_ctl.last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (mac_done) begin
                  rsp_pair_count_ff <= mac_total;
                  rsp_strobe_ff     <= 1'b1;
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_sum_echo   = rsp_sum_echo_ff;
   assign rsp_pair_count = rsp_pair_count_ff;
   assign rsp_overflowed = rsp_overflowed_ff;

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pair_sum_counter_core.
// A local histogram tracks every accepted request and works out the pair count
// for each query. Each strobed response is checked field by field against the
// oldest pending answer. The run covers directed corner cases, a heavily
// loaded bin and a long random mix with random gaps on the request side.
// ----------------------------------------------------------------------------
module tb;
   import psc_pkg::*;

   localparam int BINS        = 1024;
   localparam int TALLY_BITS  = 16;
   localparam int unsigned TALLY_LIMIT = (1 << TALLY_BITS) - 1;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;  // ignored opcode

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 8;
   localparam int DRAIN_CYCLES  = 1100;   // longest query or clear sweep, plus margin
   localparam int RANDOM_TARGET = 480;
   localparam int STEADY_ITEMS  = 60;
   localparam int HEAVY_ADDS    = 20;
   localparam longint WATCHDOG_TIME = 48_000_000;

   typedef struct {
      logic [SUM_W-1:0]  sum_echo;
      logic [PAIR_W-1:0] pair_count;
      logic              overflowed;
   } pair_answer_type;

   // all inputs known from time zero
   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                start         = 1'b0;
   logic [MODE_W-1:0]   req_mode      = MODE_ADD;
   logic [VALUE_W-1:0]  req_value     = '0;
   logic [SUM_W-1:0]    req_sum_index = '0;
   logic                busy;
   logic                rsp_strobe;
   logic [SUM_W-1:0]    rsp_sum_echo;
   logic [PAIR_W-1:0]   rsp_pair_count;
   logic                rsp_overflowed;

   // local copy of the block state
   int unsigned         bin_tally [BINS];
   int unsigned         add_total     = 0;
   logic                overflow_seen = 1'b0;
   logic [VALUE_W-1:0]  loaded_values [$];   // values counted since the last clear
   pair_answer_type     pending_answers [$];

   int error_count     = 0;
   int requests_sent   = 0;
   int answers_checked = 0;
   int clears_sent     = 0;
   int adds_dropped    = 0;

   pair_sum_counter_core #(
      .BIN_COUNT  (BINS),
      .COUNT_BITS (TALLY_BITS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .req_sum_index  (req_sum_index),
      .rsp_strobe     (rsp_strobe),
      .rsp_sum_echo   (rsp_sum_echo),
      .rsp_pair_count (rsp_pair_count),
      .rsp_overflowed (rsp_overflowed)
   );

   always #HALF_PERIOD clock = ~clock;

   // Exact self-convolution of the histogram at sum s: only the pairs
   // (k, s-k) with both indexes inside the bin range contribute.
   function automatic logic [PAIR_W-1:0] pair_total(input logic [SUM_W-1:0] s);
      longint unsigned acc;
      int lo;
      int hi;
      acc = 0;
      lo = (int'(s) > BINS - 1) ? int'(s) - (BINS - 1) : 0;
      hi = (int'(s) < BINS - 1) ? int'(s) : BINS - 1;
      for (int k = lo; k <= hi; k++)
         acc += 64'(bin_tally[k]) * 64'(bin_tally[int'(s) - k]);
      return acc[PAIR_W-1:0];
   endfunction

   // Applies one accepted request to the local state; queries queue an answer.
   function automatic void record_request(input logic [MODE_W-1:0]  mode,
                                          input logic [VALUE_W-1:0] value,
                                          input logic [SUM_W-1:0]   sum);
      pair_answer_type ans;
      case (mode)
         MODE_ADD: begin
            // at the count limit the add is dropped and the flag sticks
            if (add_total >= TALLY_LIMIT) begin
               overflow_seen = 1'b1;
               adds_dropped++;
            end else begin
               bin_tally[value]++;
               add_total++;
               loaded_values.push_back(value);
            end
         end
         MODE_QUERY: begin
            ans.sum_echo   = sum;
            ans.pair_count = pair_total(sum);
            ans.overflowed = overflow_seen;
            pending_answers.push_back(ans);
         end
         MODE_CLEAR: begin
            // clear also resets the total and the overflow flag
            foreach (bin_tally[i]) bin_tally[i] = 0;
            add_total     = 0;
            overflow_seen = 1'b0;
            loaded_values.delete();
            clears_sent++;
         end
         default: ;
      endcase
   endfunction

   // Drives one request and holds it until the block takes it (start high,
   // busy low at a rising edge). start is left high so back-to-back requests
   // need no second assignment in the same step.
   task automatic send_request(input logic [MODE_W-1:0]  mode,
                               input logic [VALUE_W-1:0] value,
                               input logic [SUM_W-1:0]   sum);
      req_mode      <= mode;
      req_value     <= value;
      req_sum_index <= sum;
      start         <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      record_request(mode, value, sum);
      requests_sent++;
   endtask

   // Gap on the request side; fields wander so the block must ignore them.
   task automatic hold_off(input int cycles);
      start         <= 1'b0;
      req_mode      <= MODE_W'($urandom_range(3));
      req_value     <= VALUE_W'($urandom);
      req_sum_index <= SUM_W'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   // Stops sending until every outstanding query has been answered.
   task automatic wait_answers_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   // Random request. Adds often repeat a loaded value so bins build up, and
   // queries mostly ask for the sum of two loaded values so counts are nonzero.
   task automatic pick_request(output logic [MODE_W-1:0]  mode,
                               output logic [VALUE_W-1:0] value,
                               output logic [SUM_W-1:0]   sum);
      int r;
      logic [VALUE_W-1:0] a;
      logic [VALUE_W-1:0] b;
      r     = $urandom_range(99);
      value = VALUE_W'($urandom_range(BINS - 1));
      sum   = SUM_W'($urandom_range((1 << SUM_W) - 1));
      if (r < 62) begin
         mode = MODE_ADD;
         if (loaded_values.size() != 0 && $urandom_range(2) == 0)
            value = loaded_values[$urandom_range(loaded_values.size() - 1)];
      end else if (r < 88) begin
         mode = MODE_QUERY;
         if (loaded_values.size() != 0 && $urandom_range(3) != 0) begin
            a   = loaded_values[$urandom_range(loaded_values.size() - 1)];
            b   = loaded_values[$urandom_range(loaded_values.size() - 1)];
            sum = {1'b0, a} + {1'b0, b};
         end
      end else if (r < 93) begin
         mode = MODE_CLEAR;
      end else begin
         mode = MODE_UNUSED;
      end
   endtask

   // Queries on an empty histogram, including the sum past the top pair.
   task automatic test_empty_histogram();
      send_request(MODE_QUERY, '0, 11'd0);
      send_request(MODE_QUERY, '0, 11'd1023);
      send_request(MODE_QUERY, '1, 11'd2046);
      send_request(MODE_QUERY, '1, 11'd2047);
   endtask

   // Every opcode at least once, with the value and sum extremes.
   task automatic test_operations();
      send_request(MODE_ADD, 10'd0, '0);
      send_request(MODE_ADD, 10'd1023, '0);
      send_request(MODE_ADD, 10'd1023, '1);
      send_request(MODE_ADD, 10'd682, '0);     // 1010101010
      send_request(MODE_ADD, 10'd341, '1);     // 0101010101
      send_request(MODE_QUERY, '1, 11'd0);
      send_request(MODE_QUERY, '0, 11'd1023);
      send_request(MODE_QUERY, '0, 11'd2046);
      send_request(MODE_QUERY, '0, 11'd1364);
      send_request(MODE_QUERY, '0, 11'd1024);  // no loaded pair adds to this
      send_request(MODE_UNUSED, 10'd1023, 11'd2047);
      send_request(MODE_QUERY, '0, 11'd1023);
      send_request(MODE_CLEAR, '1, '1);
      send_request(MODE_QUERY, '0, 11'd1023);
   endtask

   // Load the top bin many times and the bottom bin twice, then ask for the
   // edge sums and the cross sum; a clear afterwards must empty everything.
   task automatic test_heavy_bin();
      send_request(MODE_CLEAR, '0, '0);
      repeat (HEAVY_ADDS) send_request(MODE_ADD, 10'd1023, '0);
      send_request(MODE_ADD, 10'd0, '0);
      send_request(MODE_ADD, 10'd0, '0);
      send_request(MODE_QUERY, '0, 11'd2046);
      send_request(MODE_QUERY, '0, 11'd1023);
      send_request(MODE_QUERY, '0, 11'd0);
      wait_answers_drained();
      send_request(MODE_CLEAR, '0, '0);
      send_request(MODE_QUERY, '0, 11'd2046);
   endtask

   // Random mix with random gaps in some stretches and none in others; every
   // so often the sender waits for all answers before going on.
   task automatic test_random_mix();
      int items;
      bit gaps_on;
      logic [MODE_W-1:0]  mode;
      logic [VALUE_W-1:0] value;
      logic [SUM_W-1:0]   sum;
      items   = 0;
      gaps_on = 1'b1;
      while (items < RANDOM_TARGET) begin
         if (items % 50 == 0)
            gaps_on = ($urandom_range(3) != 0);
         if (items % 150 == 149)
            wait_answers_drained();
         if (gaps_on && $urandom_range(3) == 0)
            hold_off($urandom_range(1, 9));
         pick_request(mode, value, sum);
         send_request(mode, value, sum);
         items++;
      end
   endtask

   // Closing stretch: back-to-back requests, no gaps.
   task automatic test_steady_stream();
      logic [MODE_W-1:0]  mode;
      logic [VALUE_W-1:0] value;
      logic [SUM_W-1:0]   sum;
      repeat (STEADY_ITEMS) begin
         pick_request(mode, value, sum);
         send_request(mode, value, sum);
      end
   endtask

   // Response checker: no back-pressure, so every strobe is taken at the edge
   // that ends its cycle and matched against the oldest pending answer.
   always @(posedge clock) begin : answer_check
      pair_answer_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected response: sum_echo %0d pair_count %0d overflowed %0b",
                   rsp_sum_echo, rsp_pair_count, rsp_overflowed);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_sum_echo !== want.sum_echo) begin
               $error("sum_echo mismatch: expected %0d, got %0d",
                      want.sum_echo, rsp_sum_echo);
               error_count++;
            end
            if (rsp_pair_count !== want.pair_count) begin
               $error("pair_count mismatch (sum %0d): expected %0d, got %0d",
                      want.sum_echo, want.pair_count, rsp_pair_count);
               error_count++;
            end
            if (rsp_overflowed !== want.overflowed) begin
               $error("overflowed mismatch (sum %0d): expected %0b, got %0b",
                      want.sum_echo, want.overflowed, rsp_overflowed);
               error_count++;
            end
            answers_checked++;
         end
      end
   end

   // Watchdog for a hung handshake or lost responses.
   initial begin
      #(WATCHDOG_TIME);
      $display("Timeout: busy or response never settled");
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int drain_wait;
      reset <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      // the post-reset clearing sweep holds busy; send_request waits it out

      test_empty_histogram();
      test_operations();
      test_heavy_bin();
      test_random_mix();
      test_steady_stream();

      start <= 1'b0;
      drain_wait = 0;
      while (pending_answers.size() != 0 && drain_wait < 4 * DRAIN_CYCLES) begin
         @(posedge clock);
         drain_wait++;
      end
      // catch any stray strobe after the last answer
      repeat (DRAIN_CYCLES) @(posedge clock);

      foreach (pending_answers[i]) begin
         $error("no response for query of sum %0d", pending_answers[i].sum_echo);
         error_count++;
      end

      $display("Sent %0d requests: %0d clears, %0d adds dropped at the count limit.",
               requests_sent, clears_sent, adds_dropped);
      $display("Checked %0d query responses, %0d errors.", answers_checked, error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
